// ----- rtl/etd_pkg.sv -----
`default_nettype none

package etd_pkg;

    // Default working width of the number and of the running result.
    localparam int NUMBER_WIDTH_DEF = 32;

    // Field widths of the ports.
    localparam int NUMBER_PORT_W  = 32;
    localparam int TOTIENT_PORT_W = 32;

    // A zero input stands for this value.
    localparam int DEFAULT_NUMBER = 10;

    // First candidate divisor of the trial division.
    localparam int FIRST_DIVISOR = 2;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_EVAL  = 6'b001000,
        ST_LAST  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // What a running division was started for.
    typedef enum logic [1:0] {
        OP_TEST  = 2'd0,
        OP_STRIP = 2'd1,
        OP_ACC   = 2'd2,
        OP_LAST  = 2'd3
    } op_t;

endpackage : etd_pkg

`default_nettype wire

// ----- rtl/euler_totient_trial_division.sv -----
`default_nettype none

// Channel   Signals                                          Direction  Transfer when
// -------   -----------------------------------------------  ---------  ---------------------
// input     number_valid, number_ready, number[31:0]          in         valid && ready
// result    totient_valid, totient_ready, totient[31:0]       out        valid && ready
//
// Work: each division on the shared restoring divider steps through
//   NUMBER_WIDTH dividend bits and is then evaluated in ST_EVAL. Each trial
//   divisor costs one division and a setup state; each prime factor found
//   costs one extra division per power plus one to reduce the result. Worst
//   case at width 32 is about 65536 trial divisors.
// Reset: rst_n asynchronous, active low; clears the sequencer and the
//   output valid. No memory, no clearing pass.
// Stalls: the result sits in an output register; a new number is taken
//   while it waits. A finished computation holds in ST_DONE until the
//   output register is free.
module euler_totient_trial_division
    import etd_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      number_valid,
    output logic                           number_ready,
    input  wire logic [NUMBER_PORT_W-1:0]  number,

    output logic                           totient_valid,
    input  wire logic                      totient_ready,
    output logic [TOTIENT_PORT_W-1:0]      totient
);

    localparam int W     = NUMBER_WIDTH;
    localparam int CNT_W = $clog2(W + 1);

    // Sequencer and operand registers.
    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [W-1:0]     acc_reg, acc_next;      // running totient
    logic [W-1:0]     rest_reg, rest_next;    // remaining cofactor
    logic [W-1:0]     d_reg, d_next;          // candidate divisor

    // Shared divider: quo_reg holds the dividend bits still to shift in
    // and collects the quotient; rem_reg holds the partial remainder.
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvsr_reg, dvsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Output register.
    logic                      out_valid_reg, out_valid_next;
    logic [TOTIENT_PORT_W-1:0] out_data_reg, out_data_next;

    // Divider step and start request.
    logic [W:0]       div_shift;
    logic [W:0]       div_diff;
    logic             div_fit;
    logic             div_start;
    logic [W-1:0]     div_dividend;
    logic [W-1:0]     div_divisor;

    logic [W-1:0]     number_w;
    logic             number_xfer;
    logic             out_load;

    assign number_ready  = (state_reg == ST_IDLE);
    assign number_xfer   = number_valid && number_ready;
    assign totient_valid = out_valid_reg;
    assign totient       = out_data_reg;

    // Take the input modulo 2^W; zero stands for the default.
    assign number_w = W'(number);

    // One restoring step: shift in the next dividend bit, try the divisor.
    assign div_shift = {rem_reg, quo_reg[W-1]};
    assign div_diff  = div_shift - {1'b0, dvsr_reg};
    assign div_fit   = (div_shift >= {1'b0, dvsr_reg});

    // Hand the result on once the output register is free or being drained.
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || totient_ready);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        acc_next     = acc_reg;
        rest_next    = rest_reg;
        d_next       = d_reg;
        div_start    = 1'b0;
        div_dividend = rest_reg;
        div_divisor  = d_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (number_xfer)
                begin
                    if (number_w == '0)
                    begin
                        acc_next  = W'(DEFAULT_NUMBER);
                        rest_next = W'(DEFAULT_NUMBER);
                    end
                    else
                    begin
                        acc_next  = number_w;
                        rest_next = number_w;
                    end
                    d_next     = W'(FIRST_DIVISOR);
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                // Divide the cofactor by the candidate: bound test and remainder.
                div_start    = 1'b1;
                div_dividend = rest_reg;
                div_divisor  = d_reg;
                op_next      = OP_TEST;
                state_next   = ST_DIV;
            end

            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                unique case (op_reg)
                    OP_TEST:
                    begin
                        if (d_reg > quo_reg)
                        begin
                            // Divisor squared passed the cofactor: leave the loop.
                            state_next = ST_LAST;
                        end
                        else if (rem_reg == '0)
                        begin
                            rest_next    = quo_reg;
                            div_start    = 1'b1;
                            div_dividend = quo_reg;
                            div_divisor  = d_reg;
                            op_next      = OP_STRIP;
                            state_next   = ST_DIV;
                        end
                        else
                        begin
                            d_next     = d_reg + W'(1);
                            state_next = ST_CHECK;
                        end
                    end

                    OP_STRIP:
                    begin
                        if (rem_reg == '0)
                        begin
                            rest_next    = quo_reg;
                            div_start    = 1'b1;
                            div_dividend = quo_reg;
                            div_divisor  = d_reg;
                            op_next      = OP_STRIP;
                        end
                        else
                        begin
                            // Factor fully removed: reduce the result by acc/d.
                            div_start    = 1'b1;
                            div_dividend = acc_reg;
                            div_divisor  = d_reg;
                            op_next      = OP_ACC;
                        end
                        state_next = ST_DIV;
                    end

                    OP_ACC:
                    begin
                        acc_next   = acc_reg - quo_reg;
                        d_next     = d_reg + W'(1);
                        state_next = ST_CHECK;
                    end

                    OP_LAST:
                    begin
                        acc_next   = acc_reg - quo_reg;
                        state_next = ST_DONE;
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_LAST:
            begin
                // A cofactor above one is the last prime factor.
                if (rest_reg > W'(1))
                begin
                    div_start    = 1'b1;
                    div_dividend = acc_reg;
                    div_divisor  = rest_reg;
                    op_next      = OP_LAST;
                    state_next   = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Divider datapath.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;

        if (div_start)
        begin
            quo_next  = div_dividend;
            rem_next  = '0;
            dvsr_next = div_divisor;
            cnt_next  = CNT_W'(W);
        end
        else if (state_reg == ST_DIV)
        begin
            quo_next = {quo_reg[W-2:0], div_fit};
            rem_next = div_fit ? div_diff[W-1:0] : div_shift[W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Output register: drop valid on transfer, set it on load.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && totient_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = TOTIENT_PORT_W'(acc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_TEST;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        rest_reg     <= rest_next;
        d_reg        <= d_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dvsr_reg     <= dvsr_next;
        out_data_reg <= out_data_next;
    end

    // The step counter never runs dry inside a division.
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg != '0)
        else $error("divider step counter is zero during a division");

    // A finished division leaves a remainder below its divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |-> rem_reg < dvsr_reg)
        else $error("remainder not below divisor after division");

    // The divider is never run with a divisor below two.
    a_dvsr_min: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> dvsr_reg >= W'(FIRST_DIVISOR))
        else $error("division started with a divisor below two");

    // An accepted number starts the trial loop in the next cycle.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        number_valid && number_ready |=> state_reg == ST_CHECK)
        else $error("accepted number did not start the trial loop");

    // A result is loaded only into a free or draining output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || totient_ready))
        else $error("output register overwritten while full");

endmodule : euler_totient_trial_division

`default_nettype wire
